>>> rtl/fac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frustum box culling block.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int ROW_COUNT   = 4;
  localparam int ENTRY_W     = 16;           // Q4.12 matrix entry
  localparam int PLANE_W     = ENTRY_W + 1;  // Q5.12 plane entry
  localparam int COL_W       = ENTRY_W * ROW_COUNT;
  localparam int W_SHIFT     = 8;            // coordinate fraction bits

  typedef enum logic [1:0] {
    CFG_MATRIX_COL0 = 2'd0,
    CFG_MATRIX_COL1 = 2'd1,
    CFG_MATRIX_COL2 = 2'd2,
    CFG_MATRIX_COL3 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PLANE_W-1:0] w;
    logic signed [PLANE_W-1:0] z;
    logic signed [PLANE_W-1:0] y;
    logic signed [PLANE_W-1:0] x;
  } plane_t;

endpackage

>>> rtl/frustum_aabb_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_test
// Frustum visibility test of one axis-aligned box per request.
// ----------------------------------------------------------------------------
// A request is taken every cycle (busy stays low). Its visible flag reaches
// out_valid through the input register, product register and result
// register. The receiver cannot stall, so out_visible is valid only in the
// out_valid cycle. The user must load the matrix through cfg_* only while
// no request is in flight; the block itself does not enforce this. The new
// planes apply from the next request on. The zero matrix after reset culls
// every box.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_test #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [fac_pkg::COL_W-1:0]     cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_max_z,
  output logic                          out_valid,
  output logic                          out_visible
);

  fac_pkg::plane_t planes [fac_pkg::PLANE_COUNT];

  logic signed [COORD_WIDTH-1:0] min_x_r, min_y_r, min_z_r;
  logic signed [COORD_WIDTH-1:0] max_x_r, max_y_r, max_z_r;
  logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic                          v1_r, v2_r, out_valid_r;
  logic                          out_visible_r, out_visible_nxt;
  logic [fac_pkg::PLANE_COUNT-1:0] front;

  assign busy = 1'b0;

  fac_plane_gen u_plane_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (fac_pkg::cfg_reg_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      min_x_r <= in_min_x;
      min_y_r <= in_min_y;
      min_z_r <= in_min_z;
      max_x_r <= in_max_x;
      max_y_r <= in_max_y;
      max_z_r <= in_max_z;
    end
    out_visible_r <= out_visible_nxt;
  end

  // Corners may come in either order; sort each axis.
  assign lo_x = (min_x_r < max_x_r) ? min_x_r : max_x_r;
  assign hi_x = (min_x_r < max_x_r) ? max_x_r : min_x_r;
  assign lo_y = (min_y_r < max_y_r) ? min_y_r : max_y_r;
  assign hi_y = (min_y_r < max_y_r) ? max_y_r : min_y_r;
  assign lo_z = (min_z_r < max_z_r) ? min_z_r : max_z_r;
  assign hi_z = (min_z_r < max_z_r) ? max_z_r : min_z_r;

  for (genvar p = 0; p < fac_pkg::PLANE_COUNT; p++) begin : g_eval
    fac_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_plane_eval (
      .clk   (clk),
      .plane (planes[p]),
      .lo_x  (lo_x),
      .lo_y  (lo_y),
      .lo_z  (lo_z),
      .hi_x  (hi_x),
      .hi_y  (hi_y),
      .hi_z  (hi_z),
      .front (front[p])
    );
  end

  assign out_visible_nxt = &front;

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

>>> rtl/fac_plane_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_plane_gen
// Matrix column registers and the six clip planes formed from them.
// ----------------------------------------------------------------------------
module fac_plane_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  fac_pkg::cfg_reg_t             cfg_index,
  input  logic [fac_pkg::COL_W-1:0]     cfg_wdata,
  output fac_pkg::plane_t               planes [fac_pkg::PLANE_COUNT]
);

  logic [fac_pkg::COL_W-1:0] col_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r[0] <= '0;
      col_r[1] <= '0;
      col_r[2] <= '0;
      col_r[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fac_pkg::CFG_MATRIX_COL0: col_r[0] <= cfg_wdata;
        fac_pkg::CFG_MATRIX_COL1: col_r[1] <= cfg_wdata;
        fac_pkg::CFG_MATRIX_COL2: col_r[2] <= cfg_wdata;
        fac_pkg::CFG_MATRIX_COL3: col_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Plane 2k is col3 + colk, plane 2k+1 is col3 - colk, row by row.
  for (genvar p = 0; p < fac_pkg::PLANE_COUNT; p++) begin : g_plane
    logic signed [fac_pkg::PLANE_W-1:0] ent [fac_pkg::ROW_COUNT];
    for (genvar r = 0; r < fac_pkg::ROW_COUNT; r++) begin : g_row
      logic signed [fac_pkg::ENTRY_W-1:0] base;
      logic signed [fac_pkg::ENTRY_W-1:0] src;
      assign base = col_r[3][r*fac_pkg::ENTRY_W +: fac_pkg::ENTRY_W];
      assign src  = col_r[p/2][r*fac_pkg::ENTRY_W +: fac_pkg::ENTRY_W];
      if (p % 2 == 1) begin : g_sub
        assign ent[r] = fac_pkg::PLANE_W'(base) - fac_pkg::PLANE_W'(src);
      end else begin : g_add
        assign ent[r] = fac_pkg::PLANE_W'(base) + fac_pkg::PLANE_W'(src);
      end
    end
    assign planes[p].x = ent[0];
    assign planes[p].y = ent[1];
    assign planes[p].z = ent[2];
    assign planes[p].w = ent[3];
  end

endmodule

>>> rtl/fac_plane_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_plane_eval
// One plane: pick the farthest corner along the normal, multiply, register,
// then sum and test for strictly positive distance.
// ----------------------------------------------------------------------------
module fac_plane_eval #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  fac_pkg::plane_t               plane,
  input  logic signed [COORD_WIDTH-1:0] lo_x,
  input  logic signed [COORD_WIDTH-1:0] lo_y,
  input  logic signed [COORD_WIDTH-1:0] lo_z,
  input  logic signed [COORD_WIDTH-1:0] hi_x,
  input  logic signed [COORD_WIDTH-1:0] hi_y,
  input  logic signed [COORD_WIDTH-1:0] hi_z,
  output logic                          front
);

  localparam int PROD_W = fac_pkg::PLANE_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [COORD_WIDTH-1:0] sel_x, sel_y, sel_z;
  logic signed [PROD_W-1:0]      prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [PROD_W-1:0]      prod_x_r, prod_y_r, prod_z_r;
  logic signed [fac_pkg::PLANE_W-1:0] w_r;
  logic signed [SUM_W-1:0]       sum;

  // The best corner takes the low coordinate where the normal is negative.
  assign sel_x = plane.x[fac_pkg::PLANE_W-1] ? lo_x : hi_x;
  assign sel_y = plane.y[fac_pkg::PLANE_W-1] ? lo_y : hi_y;
  assign sel_z = plane.z[fac_pkg::PLANE_W-1] ? lo_z : hi_z;

  assign prod_x_nxt = PROD_W'(plane.x) * PROD_W'(sel_x);
  assign prod_y_nxt = PROD_W'(plane.y) * PROD_W'(sel_y);
  assign prod_z_nxt = PROD_W'(plane.z) * PROD_W'(sel_z);

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    prod_z_r <= prod_z_nxt;
    w_r      <= plane.w;
  end

  assign sum = SUM_W'(prod_x_r) + SUM_W'(prod_y_r) + SUM_W'(prod_z_r)
             + (SUM_W'(w_r) <<< fac_pkg::W_SHIFT);

  assign front = !sum[SUM_W-1] && (sum != '0);

endmodule

>>> rtl/fac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_checker
// Port-level checks of request to result timing for the culling block.
// ----------------------------------------------------------------------------
module fac_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_visible
);

  // Every result traces back to an earlier accepted request.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching request");

  // A request taken out of reset always yields its result.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy, 3) && $past(rst_n, 1) && $past(rst_n, 2)
     && $past(rst_n, 3)) |-> out_valid)
    else $error("request dropped");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request refused");

  a_known_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_visible))
    else $error("result flag unknown");

endmodule

bind frustum_aabb_cull_test fac_checker u_fac_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_visible (out_visible)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for frustum_aabb_cull_test. Boxes are sent in requests, under a
// sequence of matrix settings: reset zero, a unit cube, the entry extremes,
// projection-like and plain random matrices. A scoreboard predicts the visible
// flag of each accepted request and checks every result strobe against it in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW = 24;
  localparam logic [fac_pkg::ENTRY_W-1:0] Q_MAX = 16'h7fff;
  localparam logic [fac_pkg::ENTRY_W-1:0] Q_MIN = 16'h8000;
  localparam logic [fac_pkg::ENTRY_W-1:0] Q_ONE = 16'h1000;
  localparam int C_ONE = 256;  // 1.0 in coordinate format

  typedef struct packed {
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] hi_z;
  } box_t;

  class cull_scoreboard;
    logic [fac_pkg::COL_W-1:0] col[fac_pkg::ROW_COUNT];
    bit                        visible_q[$];
    int                        errors;

    function new();
      foreach (col[i]) col[i] = '0;
      errors = 0;
    endfunction

    function void set_col(int idx, logic [fac_pkg::COL_W-1:0] value);
      col[idx] = value;
    endfunction

    function longint entry(int c, int r);
      logic signed [fac_pkg::ENTRY_W-1:0] e;
      e = col[c][r*fac_pkg::ENTRY_W +: fac_pkg::ENTRY_W];
      return longint'(e);
    endfunction

    function bit box_visible(box_t b);
      longint lo[3];
      longint hi[3];
      longint pl[4];
      longint d;
      longint x;
      longint y;
      longint z;
      bit     vis;
      bit     front;
      vis = 1'b1;
      lo[0] = b.lo_x; lo[1] = b.lo_y; lo[2] = b.lo_z;
      hi[0] = b.hi_x; hi[1] = b.hi_y; hi[2] = b.hi_z;
      for (int p = 0; p < fac_pkg::PLANE_COUNT; p++) begin
        for (int r = 0; r < fac_pkg::ROW_COUNT; r++) begin
          pl[r] = (p % 2) ? entry(3, r) - entry(p / 2, r) : entry(3, r) + entry(p / 2, r);
        end
        front = 1'b0;
        for (int c = 0; c < 8; c++) begin
          x = (c & 1) ? hi[0] : lo[0];
          y = (c & 2) ? hi[1] : lo[1];
          z = (c & 4) ? hi[2] : lo[2];
          d = pl[0] * x + pl[1] * y + pl[2] * z
            + pl[3] * (longint'(1) << fac_pkg::W_SHIFT);
          if (d > 0) front = 1'b1;
        end
        if (!front) vis = 1'b0;
      end
      return vis;
    endfunction

    function void note_request(box_t b);
      visible_q = {visible_q, box_visible(b)};
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic vis);
      bit want;
      if (visible_q.size() == 0) begin
        report_mismatch($sformatf("result visible=%b with no pending request", vis));
      end else begin
        want = visible_q.pop_front();
        if (vis !== want) begin
          report_mismatch($sformatf("visible=%b, predicted %b", vis, want));
        end
      end
    endtask

    function int pending();
      return visible_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [fac_pkg::COL_W-1:0] cfg_wdata = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [CW-1:0]      in_min_x = '0;
  logic signed [CW-1:0]      in_min_y = '0;
  logic signed [CW-1:0]      in_min_z = '0;
  logic signed [CW-1:0]      in_max_x = '0;
  logic signed [CW-1:0]      in_max_y = '0;
  logic signed [CW-1:0]      in_max_z = '0;
  logic                      out_valid;
  logic                      out_visible;

  cull_scoreboard sb = new();
  int idle_odds;  // pause before a request with probability 1/idle_odds, 0 = never

  frustum_aabb_cull_test #(.COORD_WIDTH(CW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_min_x   (in_min_x),
    .in_min_y   (in_min_y),
    .in_min_z   (in_min_z),
    .in_max_x   (in_max_x),
    .in_max_y   (in_max_y),
    .in_max_z   (in_max_z),
    .out_valid  (out_valid),
    .out_visible(out_visible)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("frustum_aabb_cull_test verification failed");
    $finish;
  end

  // Observe config writes, accepted requests and result strobes at each edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_col(cfg_index, cfg_wdata);
      if (start && busy === 1'b0) begin
        sb.note_request('{in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z});
      end
      if (out_valid === 1'b1) sb.check_result(out_visible);
      else if (out_valid !== 1'b0) sb.report_mismatch("out_valid is unknown");
    end
  end

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo_x = CW'(lx); b.lo_y = CW'(ly); b.lo_z = CW'(lz);
    b.hi_x = CW'(hx); b.hi_y = CW'(hy); b.hi_z = CW'(hz);
    return b;
  endfunction

  function automatic box_t wide_box();
    return make_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  function automatic int near_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Box centered within +/- span, extents up to a quarter span, sometimes reversed.
  function automatic box_t near_box(int span);
    int c[3];
    int e[3];
    box_t b;
    foreach (c[i]) begin
      c[i] = near_coord(span);
      e[i] = $urandom_range(0, span / 4);
    end
    b = make_box(c[0] - e[0], c[1] - e[1], c[2] - e[2], c[0] + e[0], c[1] + e[1], c[2] + e[2]);
    if ($urandom_range(0, 9) == 0) begin
      b = make_box(b.hi_x, b.hi_y, b.hi_z, b.lo_x, b.lo_y, b.lo_z);
    end
    return b;
  endfunction

  function automatic logic [fac_pkg::COL_W-1:0] pack_col(int r0, int r1, int r2, int r3);
    return {r3[15:0], r2[15:0], r1[15:0], r0[15:0]};
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 1024)) - 512;
  endfunction

  task automatic pause_requests(int n);
    start <= 1'b0;
    // park junk on the fields while no request is offered
    in_min_x <= CW'($urandom()); in_min_y <= CW'($urandom()); in_min_z <= CW'($urandom());
    in_max_x <= CW'($urandom()); in_max_y <= CW'($urandom()); in_max_z <= CW'($urandom());
    repeat (n) @(posedge clk);
  endtask

  task automatic issue_box(box_t b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      pause_requests($urandom_range(1, 17));
    end
    start    <= 1'b1;
    in_min_x <= b.lo_x; in_min_y <= b.lo_y; in_min_z <= b.lo_z;
    in_max_x <= b.hi_x; in_max_y <= b.hi_y; in_max_z <= b.hi_z;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and hold until every predicted result has come back.
  task automatic settle_pipeline();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(fac_pkg::cfg_reg_t idx, logic [fac_pkg::COL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [fac_pkg::COL_W-1:0] c0, logic [fac_pkg::COL_W-1:0] c1,
                             logic [fac_pkg::COL_W-1:0] c2, logic [fac_pkg::COL_W-1:0] c3);
    write_reg(fac_pkg::CFG_MATRIX_COL0, c0);
    write_reg(fac_pkg::CFG_MATRIX_COL1, c1);
    write_reg(fac_pkg::CFG_MATRIX_COL2, c2);
    write_reg(fac_pkg::CFG_MATRIX_COL3, c3);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_near_phase(int n_items, int span);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) issue_box(wide_box());
      else issue_box(near_box(span));
    end
  endtask

  initial begin
    logic [fac_pkg::COL_W-1:0] m[fac_pkg::ROW_COUNT];
    int a[3];
    int b;

    idle_odds = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset matrix: every box is culled.
    issue_box(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    issue_box(make_box(0, 0, 0, 0, 0, 0));
    issue_box(wide_box());
    settle_pipeline();

    // Unit cube: planes w +/- x, w +/- y, w +/- z.
    load_matrix(pack_col(Q_ONE, 0, 0, 0), pack_col(0, Q_ONE, 0, 0),
                pack_col(0, 0, Q_ONE, 0), pack_col(0, 0, 0, Q_ONE));
    idle_odds = 3;
    issue_box(make_box(-10, -10, -10, 10, 10, 10));
    issue_box(make_box(0, 0, 0, 0, 0, 0));
    issue_box(make_box(300, 0, 0, 400, 10, 10));
    issue_box(make_box(C_ONE, 0, 0, 400, 10, 10));
    issue_box(make_box(C_ONE - 1, 0, 0, 400, 10, 10));
    issue_box(make_box(-400, 0, 0, -C_ONE, 10, 10));
    issue_box(make_box(-400, 0, 0, -C_ONE + 1, 10, 10));
    issue_box(make_box(0, C_ONE, 0, 5, 900, 5));
    issue_box(make_box(0, 0, -900, 5, 5, -C_ONE));
    issue_box(make_box(10, 10, 10, -10, -10, -10));
    issue_box(make_box(400, 10, 10, 300, 0, 0));
    issue_box(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    issue_box(make_box(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    issue_box(make_box(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    issue_box(make_box(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    issue_box(make_box(-8388608, -10, 300, 8388607, 10, 500));
    issue_box(make_box(-C_ONE, -C_ONE, -C_ONE, -C_ONE, -C_ONE, -C_ONE));
    issue_box(make_box(-C_ONE + 1, -C_ONE + 1, -C_ONE + 1, -C_ONE + 1, -C_ONE + 1, -C_ONE + 1));
    settle_pipeline();

    // Entry extremes: widest plane entries of both signs.
    load_matrix({4{Q_MAX}}, {4{Q_MAX}}, {4{Q_MAX}}, {4{Q_MAX}});
    run_near_phase(30, 8000);
    settle_pipeline();
    load_matrix({4{Q_MIN}}, {4{Q_MIN}}, {4{Q_MIN}}, {4{Q_MIN}});
    run_near_phase(30, 8000);
    settle_pipeline();
    load_matrix({4{Q_MAX}}, {4{Q_MIN}}, {4{Q_MAX}}, {4{Q_MIN}});
    run_near_phase(30, 8000);
    settle_pipeline();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        foreach (m[i]) m[i] = {$urandom(), $urandom()};
      end else begin
        // Projection-like: scaled axes with offset and some cross-talk.
        foreach (a[i]) a[i] = $urandom_range(2048, 8192);
        b = $urandom_range(4096, 28000);
        m[0] = pack_col(a[0] + jitter(), jitter(), jitter(), jitter());
        m[1] = pack_col(jitter(), a[1] + jitter(), jitter(), jitter());
        m[2] = pack_col(jitter(), jitter(), a[2] + jitter(), jitter());
        m[3] = pack_col(near_coord(4096), near_coord(4096), near_coord(4096), b);
      end
      load_matrix(m[0], m[1], m[2], m[3]);
      case (ph % 3)
        0: idle_odds = 2;
        1: idle_odds = 0;
        default: idle_odds = 5;
      endcase
      if (ph == 7) idle_odds = 0;
      run_near_phase(90, 6000);
      settle_pipeline();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d predicted results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("frustum_aabb_cull_test verification clean");
    end else begin
      $display("frustum_aabb_cull_test verification failed");
    end
    $finish;
  end

endmodule
